// File: hw/rtl/ssc_pkg.sv
// ssc_pkg: shared types and constants for the servo slew steering controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int NUM_CH = 3;

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_TARGET = 2'd1;
    localparam logic [1:0] REQ_STEER  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_STEP = 2'd0;
    localparam logic [1:0] CFG_CENTER   = 2'd1;
    localparam logic [1:0] CFG_LEFT     = 2'd2;
    localparam logic [1:0] CFG_RIGHT    = 2'd3;

    // configuration reset values
    localparam logic [7:0]         MAX_STEP_RESET = 8'd6;
    localparam logic [7:0]         CENTER_RESET   = 8'd128;
    localparam logic [14:0]        LEFT_RESET     = 15'd5200;
    localparam logic signed [15:0] RIGHT_RESET    = -16'sd5000;

    // setpoint range and saturation
    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [7:0] SAT_LO     = 8'd20;
    localparam logic [7:0] SAT_HI     = 8'd235;

    // duty = setpoint * 75 / 16 + 900
    localparam logic [6:0]  DUTY_MUL   = 7'd75;
    localparam int          DUTY_SHIFT = 4;
    localparam logic [11:0] DUTY_OFS   = 12'd900;

    // divider widths: dividend magnitude and divisor magnitude
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic fwd_start;
        logic fwd_finish;
        logic back_start;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic req_steer;
        logic div_done;
    } t_dp_stat;

endpackage

// File: hw/rtl/ssc_div.sv
// ssc_div: unsigned restoring divider, one quotient bit per cycle
// depends on ssc_pkg for the operand widths
`timescale 1ns / 1ps

module ssc_div import ssc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic [DIV_NW-1:0] o_quotient,
    output logic              o_done
);

    localparam int              CNT_W    = $clog2(DIV_NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NW - 1);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: hw/rtl/ssc_dp.sv
// ssc_dp: setpoint state, configuration registers, steering arithmetic and result register
// depends on ssc_pkg and ssc_div
`timescale 1ns / 1ps

module ssc_dp import ssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_req_type,
    input  logic [1:0]         i_channel,
    input  logic [7:0]         i_setpoint,
    input  logic signed [15:0] i_angle,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic [11:0]        o_duty_steer,
    output logic [11:0]        o_duty_second,
    output logic [11:0]        o_duty_third,
    output logic [7:0]         o_target_steer,
    output logic [7:0]         o_target_second,
    output logic [7:0]         o_target_third,
    output logic signed [15:0] o_steer_angle_out
);

    function automatic logic [11:0] duty_of(input logic [7:0] sp);
        logic [14:0] p;
        p = sp * DUTY_MUL;
        return 12'(p >> DUTY_SHIFT) + DUTY_OFS;
    endfunction

    logic [7:0]         r_max_step;
    logic [7:0]         r_center;
    logic [14:0]        r_left;
    logic signed [15:0] r_right;
    logic [7:0]         r_act [NUM_CH];
    logic [7:0]         r_tgt [NUM_CH];
    logic signed [15:0] r_ang;
    logic [1:0]         r_req;
    logic               r_qneg;
    logic               r_back_le;

    logic [11:0]        r_o_duty [NUM_CH];
    logic [7:0]         r_o_tgt [NUM_CH];
    logic signed [15:0] r_o_ang;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= MAX_STEP_RESET;
            r_center   <= CENTER_RESET;
            r_left     <= LEFT_RESET;
            r_right    <= RIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_STEP: r_max_step <= i_cfg_data[7:0];
                CFG_CENTER:   r_center   <= i_cfg_data[7:0];
                CFG_LEFT:     r_left     <= i_cfg_data[14:0];
                CFG_RIGHT:    r_right    <= $signed(i_cfg_data);
            endcase
        end
    end

    // divider
    logic              div_start;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic [DIV_NW-1:0] div_quo;
    logic              div_done;

    ssc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // angle to target operands
    logic               ang_pos;
    logic [14:0]        ang_pos_c;
    logic [14:0]        left_diff;
    logic signed [15:0] ang_neg_c;
    logic [15:0]        ang_neg_mag;
    logic [15:0]        right_mag;
    logic [7:0]         span;
    logic [22:0]        prod_l;
    logic [23:0]        prod_r;
    logic [DIV_NW-1:0]  fwd_n;
    logic [DIV_DW-1:0]  fwd_d;
    logic               fwd_neg;

    assign ang_pos     = !r_ang[15];
    assign ang_pos_c   = (r_ang[14:0] > r_left) ? r_left : r_ang[14:0];
    assign left_diff   = r_left - ang_pos_c;
    assign ang_neg_c   = (r_ang < r_right) ? r_right : r_ang;
    assign ang_neg_mag = ang_neg_c[15] ? (~ang_neg_c + 16'd1) : ang_neg_c;
    assign right_mag   = r_right[15] ? (~r_right + 16'd1) : r_right;
    assign span        = FULL_SCALE - r_center;
    assign prod_l      = left_diff * r_center;
    assign prod_r      = span * ang_neg_mag;

    always_comb begin
        fwd_neg = 1'b0;
        if (ang_pos) begin
            if (r_left == '0) begin
                fwd_n = DIV_NW'(r_center);
                fwd_d = DIV_DW'(1);
            end else begin
                fwd_n = DIV_NW'(prod_l);
                fwd_d = DIV_DW'(r_left);
            end
        end else begin
            if (r_right == '0) begin
                fwd_n = '0;
                fwd_d = DIV_DW'(1);
            end else begin
                fwd_n   = prod_r;
                fwd_d   = right_mag;
                fwd_neg = ang_neg_c[15] ^ r_right[15];
            end
        end
    end

    // target to angle operands
    logic        back_le;
    logic [7:0]  tgt_over;
    logic [22:0] prod_bl;
    logic [23:0] prod_br;
    logic [DIV_NW-1:0] back_n;
    logic [DIV_DW-1:0] back_d;

    assign back_le  = (r_tgt[0] <= r_center);
    assign tgt_over = r_tgt[0] - r_center;
    assign prod_bl  = r_left * r_tgt[0];
    assign prod_br  = right_mag * tgt_over;

    always_comb begin
        if (back_le) begin
            back_n = DIV_NW'(prod_bl);
            back_d = (r_center == '0) ? DIV_DW'(1) : DIV_DW'(r_center);
        end else begin
            back_n = prod_br;
            back_d = DIV_DW'(span);
        end
    end

    assign div_start    = i_cmd.fwd_start | i_cmd.back_start;
    assign div_dividend = i_cmd.fwd_start ? fwd_n : back_n;
    assign div_divisor  = i_cmd.fwd_start ? fwd_d : back_d;

    // angle to target result with saturation
    logic signed [25:0] q_s;
    logic signed [25:0] fwd_v;
    logic [7:0]         fwd_sat;

    assign q_s   = r_qneg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    assign fwd_v = q_s + (ang_pos ? 26'sd0 : $signed(26'(r_center)));

    always_comb begin
        if (fwd_v < $signed(26'(SAT_LO))) begin
            fwd_sat = SAT_LO;
        end else if (fwd_v > $signed(26'(SAT_HI))) begin
            fwd_sat = SAT_HI;
        end else begin
            fwd_sat = fwd_v[7:0];
        end
    end

    // target to angle result
    logic [15:0] q16;
    logic [15:0] back_ang;

    assign q16      = div_quo[15:0];
    assign back_ang = r_back_le ? ({1'b0, r_left} - q16) : (r_qneg ? (~q16 + 16'd1) : q16);

    // divide sign and branch flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_start) begin
            r_qneg <= fwd_neg;
        end else if (i_cmd.back_start) begin
            r_qneg    <= r_right[15];
            r_back_le <= back_le;
        end
    end

    // setpoint state: tick slew, target writes, steering result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_act[i] <= CENTER_RESET;
                r_tgt[i] <= CENTER_RESET;
            end
        end else if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_ang <= i_angle;
            if (i_req_type == REQ_TICK) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if ({1'b0, r_act[i]} > ({1'b0, r_tgt[i]} + {1'b0, r_max_step})) begin
                        r_act[i] <= r_act[i] - r_max_step;
                    end else if (({1'b0, r_act[i]} + {1'b0, r_max_step}) < {1'b0, r_tgt[i]}) begin
                        r_act[i] <= r_act[i] + r_max_step;
                    end else begin
                        r_act[i] <= r_tgt[i];
                    end
                end
            end else if (i_req_type == REQ_TARGET) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (i_channel == 2'(i)) begin
                        r_tgt[i] <= i_setpoint;
                    end
                end
            end
        end else if (i_cmd.fwd_finish && (r_req == REQ_STEER)) begin
            r_tgt[0] <= fwd_sat;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_o_duty[i] <= duty_of(r_act[i]);
                r_o_tgt[i]  <= r_tgt[i];
            end
            r_o_ang <= $signed(back_ang);
        end
    end

    assign o_stat.req_steer = (i_req_type == REQ_STEER);
    assign o_stat.div_done  = div_done;

    assign o_duty_steer      = r_o_duty[0];
    assign o_duty_second     = r_o_duty[1];
    assign o_duty_third      = r_o_duty[2];
    assign o_target_steer    = r_o_tgt[0];
    assign o_target_second   = r_o_tgt[1];
    assign o_target_third    = r_o_tgt[2];
    assign o_steer_angle_out = r_o_ang;

endmodule

// File: hw/rtl/ssc_ctrl.sv
// ssc_ctrl: sequencing state machine and handshake control
// depends on ssc_pkg for the command and status structs
`timescale 1ns / 1ps

module ssc_ctrl import ssc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE       = 6'b000001,
        S_FWD_START  = 6'b000010,
        S_FWD_WAIT   = 6'b000100,
        S_BACK_START = 6'b001000,
        S_BACK_WAIT  = 6'b010000,
        S_OUT        = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    // next state and commands
    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = i_stat.req_steer ? S_FWD_START : S_BACK_START;
                end
            end
            S_FWD_START: begin
                cmd.fwd_start = 1'b1;
                n_state       = S_FWD_WAIT;
            end
            S_FWD_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.fwd_finish = 1'b1;
                    n_state        = S_BACK_START;
                end
            end
            S_BACK_START: begin
                cmd.back_start = 1'b1;
                n_state        = S_BACK_WAIT;
            end
            S_BACK_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // an accepted transaction leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start processing");

    // loading the result register always raises output valid
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_valid)
        else $error("result loaded without output valid");

    // a finished forward divide moves on to the readback divide
    a_fwd_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWD_WAIT && i_stat.div_done) |=> (r_state == S_BACK_START))
        else $error("forward divide completion not followed by readback");

    // divider starts only from the start states
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fwd_start || cmd.back_start) |-> (r_state == S_FWD_START || r_state == S_BACK_START))
        else $error("divider started outside a start state");

endmodule

// File: hw/rtl/servo_slew_steering_controller_core.sv
// Three-channel servo slew limiter with a steering front end. Each transaction is a tick
// (every actual setpoint moves toward its target by at most max_step), a target write to one
// channel, or a steering angle mapped onto channel 0's target; every transaction returns one
// result with the three duties, the three targets and the angle read back from channel 0.
// One transaction is in flight at a time. The shared 24-step bit-serial divider runs once for
// the readback angle of every transaction and once more for the steering mapping of a steering
// angle. A finished result sits in an output register, and the next transaction is accepted
// while it waits to be taken.
// depends on ssc_pkg, ssc_ctrl and ssc_dp
`timescale 1ns / 1ps

module servo_slew_steering_controller_core import ssc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [1:0]         i_channel,
    input  logic [7:0]         i_setpoint,
    input  logic signed [15:0] i_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_duty_steer,
    output logic [11:0]        o_duty_second,
    output logic [11:0]        o_duty_third,
    output logic [7:0]         o_target_steer,
    output logic [7:0]         o_target_second,
    output logic [7:0]         o_target_third,
    output logic signed [15:0] o_steer_angle_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    ssc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // arithmetic and state
    ssc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_channel         (i_channel),
        .i_setpoint        (i_setpoint),
        .i_angle           (i_angle),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .o_duty_steer      (o_duty_steer),
        .o_duty_second     (o_duty_second),
        .o_duty_third      (o_duty_third),
        .o_target_steer    (o_target_steer),
        .o_target_second   (o_target_second),
        .o_target_third    (o_target_third),
        .o_steer_angle_out (o_steer_angle_out)
    );

endmodule
